// ===== rtl/grd_pkg.sv =====
// grd_pkg: shared types and constants of the glyph row delta decompressor
// holds the payload structs, the memory request struct and status codes
// no dependencies
`timescale 1ns / 1ps

package grd_pkg;

  localparam int unsigned ROW_BYTES_DEFAULT = 32;

  localparam logic [6:0] COL_MAX = 7'd127;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVF     = 2'd1;
  localparam logic [1:0] ST_UNTERM  = 2'd2;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       glyph_start;
    logic [5:0] row_bytes;
    logic       glyph_last;
  } grd_in_t;

  typedef struct packed {
    logic [63:0] row_chunk;
    logic [1:0]  chunk_index;
    logic [4:0]  repeat_times;
    logic        row_done;
    logic        glyph_done;
    logic [1:0]  status;
  } grd_out_t;

  typedef struct packed {
    logic       clr;
    logic       we;
    logic [6:0] wcol;
    logic [7:0] wdata;
    logic       re;
    logic [6:0] rcol;
  } grd_mem_req_t;

endpackage

// ===== rtl/grd_row_mem.sv =====
// grd_row_mem: row store as a word memory of eight byte lanes
// one byte write and one registered word read per cycle, per-byte valid bits
// depends on grd_pkg
`timescale 1ns / 1ps

module grd_row_mem #(
  parameter int unsigned ROW_BYTES = grd_pkg::ROW_BYTES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  grd_pkg::grd_mem_req_t req_i,
  output logic [7:0][7:0]       rbytes_o
);
  import grd_pkg::*;

  localparam int unsigned NW = (ROW_BYTES + 7) / 8;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;

  logic [63:0]   mem_q [NW];
  logic [7:0]    valid_q [NW];
  logic [63:0]   rdata_q;
  logic [AW-1:0] raddr_q;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [2:0]    wlane;

  assign waddr = AW'(req_i.wcol >> 3);
  assign raddr = AW'(req_i.rcol >> 3);
  assign wlane = req_i.wcol[2:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr][8*wlane +: 8] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[raddr];
      raddr_q <= raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) valid_q[i] <= '0;
    end else if (req_i.clr) begin
      for (int i = 0; i < NW; i++) valid_q[i] <= '0;
    end else if (req_i.we) begin
      valid_q[waddr][wlane] <= 1'b1;
    end
  end

  // unwritten bytes read as zero
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      rbytes_o[b] = valid_q[raddr_q][b] ? rdata_q[8*b +: 8] : 8'h00;
    end
  end

endmodule

// ===== rtl/grd_ctrl.sv =====
// grd_ctrl: command decoder and sequencer of the row decompressor
// read-modify-write of the row store, fills, shifts and chunked row emission
// depends on grd_pkg and drives grd_row_mem
`timescale 1ns / 1ps

module grd_ctrl #(
  parameter int unsigned ROW_BYTES = grd_pkg::ROW_BYTES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  grd_pkg::grd_in_t      in_data_i,
  output grd_pkg::grd_mem_req_t mem_req_o,
  input  logic [7:0][7:0]       mem_rbytes_i,
  input  logic                  out_free_i,
  output logic                  out_load_o,
  output grd_pkg::grd_out_t     out_item_o
);
  import grd_pkg::*;

  localparam int unsigned MAXW = (ROW_BYTES < 32) ? ROW_BYTES : 32;

  localparam logic [3:0] OP_SKIP_LIT1     = 4'd0;
  localparam logic [3:0] OP_SKIP_LIT1_END = 4'd1;
  localparam logic [3:0] OP_LITS          = 4'd2;
  localparam logic [3:0] OP_LITS_END      = 4'd3;
  localparam logic [3:0] OP_SHL           = 4'd4;
  localparam logic [3:0] OP_SHL_END       = 4'd5;
  localparam logic [3:0] OP_SHR           = 4'd6;
  localparam logic [3:0] OP_SHR_END       = 4'd7;
  localparam logic [3:0] OP_SKIP          = 4'd8;
  localparam logic [3:0] OP_REPEAT        = 4'd9;
  localparam logic [3:0] OP_FILL_ONES     = 4'd10;
  localparam logic [3:0] OP_FILL_ZEROS    = 4'd11;
  localparam logic [3:0] OP_SKIP_LIT2     = 4'd12;
  localparam logic [3:0] OP_SKIP_LIT2_END = 4'd13;
  localparam logic [3:0] OP_END_ROW       = 4'd14;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SHIFT,
    S_EMIT_RD,
    S_EMIT_WR
  } state_e;

  function automatic logic [6:0] col_add(logic [6:0] c, logic [4:0] n);
    logic [7:0] s;
    s = {1'b0, c} + {3'b000, n};
    return (s > {1'b0, COL_MAX}) ? COL_MAX : s[6:0];
  endfunction

  state_e     state_q, state_d;
  logic [6:0] col_q, col_d;
  logic [4:0] lit_q, lit_d;
  logic       endl_q, endl_d;
  logic [4:0] rc_q, rc_d;
  logic [5:0] w_q, w_d;
  logic       ovf_q, ovf_d;
  logic [4:0] fill_left_q, fill_left_d;
  logic       fill_ones_q, fill_ones_d;
  logic       shl_q, shl_d;
  logic       shin_q, shin_d;
  logic       pend_end_q, pend_end_d;
  logic       pend_last_q, pend_last_d;
  logic [1:0] chunk_q, chunk_d;

  logic [6:0]  e_col;
  logic [4:0]  e_lit;
  logic        e_end;
  logic [4:0]  e_rc;
  logic [5:0]  e_w;
  logic        e_ovf;
  logic [5:0]  w_clamp;
  logic [13:0] prod;
  logic [3:0]  op;
  logic [7:0]  op18;
  logic [4:0]  cnt;
  logic [6:0]  mv;
  logic [6:0]  c1;
  logic        nxt_end;
  logic        multi;
  logic [7:0]  sh_n;
  logic [7:0]  sh_m;
  logic        last_chunk;

  assign in_ready_o = (state_q == S_IDLE);
  assign last_chunk = (chunk_q == 2'((w_q - 6'd1) >> 3));

  // op = byte / 18 by reciprocal, exact over all byte values
  assign prod = {6'b000000, in_data_i.code_byte} * 14'd57;
  assign op   = prod[13:10];
  assign op18 = {4'b0000, op} * 8'd18;
  assign cnt  = 5'(in_data_i.code_byte - op18);

  always_comb begin
    if (in_data_i.row_bytes == 6'd0) begin
      w_clamp = 6'd1;
    end else if (in_data_i.row_bytes > 6'(MAXW)) begin
      w_clamp = 6'(MAXW);
    end else begin
      w_clamp = in_data_i.row_bytes;
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      out_item_o.row_chunk[63-8*b -: 8] =
          ({1'b0, chunk_q, 3'(b)} < w_q) ? mem_rbytes_i[b] : 8'h00;
    end
    out_item_o.chunk_index  = chunk_q;
    out_item_o.repeat_times = rc_q + 5'd1;
    out_item_o.row_done     = last_chunk;
    out_item_o.glyph_done   = pend_last_q;
    out_item_o.status       = pend_end_q ? (ovf_q ? ST_OVF : ST_OK) : ST_UNTERM;
  end

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    lit_d       = lit_q;
    endl_d      = endl_q;
    rc_d        = rc_q;
    w_d         = w_q;
    ovf_d       = ovf_q;
    fill_left_d = fill_left_q;
    fill_ones_d = fill_ones_q;
    shl_d       = shl_q;
    shin_d      = shin_q;
    pend_end_d  = pend_end_q;
    pend_last_d = pend_last_q;
    chunk_d     = chunk_q;
    mem_req_o   = '0;
    out_load_o  = 1'b0;
    nxt_end     = 1'b0;
    multi       = 1'b0;
    sh_n        = 8'h00;
    sh_m        = 8'h00;
    c1          = col_add(col_q, 5'd1);

    e_col = in_data_i.glyph_start ? 7'd0 : col_q;
    e_lit = in_data_i.glyph_start ? 5'd0 : lit_q;
    e_end = in_data_i.glyph_start ? 1'b0 : endl_q;
    e_rc  = in_data_i.glyph_start ? 5'd0 : rc_q;
    e_w   = in_data_i.glyph_start ? w_clamp : w_q;
    e_ovf = in_data_i.glyph_start ? 1'b0 : ovf_q;
    mv    = col_add(e_col, cnt);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mem_req_o.clr = in_data_i.glyph_start;
          w_d    = e_w;
          rc_d   = e_rc;
          col_d  = e_col;
          lit_d  = e_lit;
          endl_d = e_end;
          ovf_d  = e_ovf;
          if (e_lit != 5'd0) begin
            // pending literal byte
            mem_req_o.we    = (e_col < {1'b0, e_w});
            mem_req_o.wcol  = e_col;
            mem_req_o.wdata = in_data_i.code_byte;
            col_d = col_add(e_col, 5'd1);
            ovf_d = e_ovf | (col_add(e_col, 5'd1) > {1'b0, e_w});
            lit_d = e_lit - 5'd1;
            if (e_lit == 5'd1 && e_end) begin
              endl_d  = 1'b0;
              nxt_end = 1'b1;
            end
          end else begin
            case (op)
              OP_SKIP_LIT1, OP_SKIP_LIT1_END: begin
                col_d  = mv;
                ovf_d  = e_ovf | (mv > {1'b0, e_w});
                lit_d  = 5'd1;
                endl_d = (op == OP_SKIP_LIT1_END);
              end
              OP_SKIP_LIT2, OP_SKIP_LIT2_END: begin
                col_d  = mv;
                ovf_d  = e_ovf | (mv > {1'b0, e_w});
                lit_d  = 5'd2;
                endl_d = (op == OP_SKIP_LIT2_END);
              end
              OP_LITS, OP_LITS_END: begin
                lit_d  = cnt + 5'd1;
                endl_d = (op == OP_LITS_END);
              end
              OP_SHL, OP_SHL_END, OP_SHR, OP_SHR_END: begin
                col_d          = mv;
                ovf_d          = e_ovf | (mv > {1'b0, e_w});
                mem_req_o.re   = 1'b1;
                mem_req_o.rcol = mv;
                shin_d         = (mv < {1'b0, e_w});
                shl_d          = (op == OP_SHL) || (op == OP_SHL_END);
                pend_end_d     = (op == OP_SHL_END) || (op == OP_SHR_END);
                pend_last_d    = in_data_i.glyph_last;
                multi          = 1'b1;
                state_d        = S_SHIFT;
              end
              OP_SKIP: begin
                col_d = col_add(e_col, cnt + 5'd1);
                ovf_d = e_ovf | (col_add(e_col, cnt + 5'd1) > {1'b0, e_w});
              end
              OP_REPEAT: begin
                rc_d    = cnt;
                nxt_end = 1'b1;
              end
              OP_FILL_ONES, OP_FILL_ZEROS: begin
                fill_left_d = cnt + 5'd1;
                fill_ones_d = (op == OP_FILL_ONES);
                pend_end_d  = 1'b0;
                pend_last_d = in_data_i.glyph_last;
                multi       = 1'b1;
                state_d     = S_FILL;
              end
              OP_END_ROW: begin
                nxt_end = 1'b1;
              end
              default: begin
              end
            endcase
          end
          if (!multi && (nxt_end || in_data_i.glyph_last)) begin
            pend_end_d  = nxt_end;
            pend_last_d = in_data_i.glyph_last;
            chunk_d     = 2'd0;
            state_d     = S_EMIT_RD;
          end
        end
      end

      S_FILL: begin
        mem_req_o.we    = (col_q < {1'b0, w_q});
        mem_req_o.wcol  = col_q;
        mem_req_o.wdata = fill_ones_q ? 8'hFF : 8'h00;
        col_d       = c1;
        ovf_d       = ovf_q | (c1 > {1'b0, w_q});
        fill_left_d = fill_left_q - 5'd1;
        if (fill_left_q == 5'd1) begin
          chunk_d = 2'd0;
          state_d = pend_last_q ? S_EMIT_RD : S_IDLE;
        end
      end

      S_SHIFT: begin
        sh_n = shin_q ? mem_rbytes_i[col_q[2:0]] : 8'h00;
        if (shl_q) begin
          if (sh_n == 8'h00) begin
            sh_m = 8'h01;
          end else if (sh_n == 8'hFF) begin
            sh_m = 8'hFE;
          end else begin
            sh_m = {sh_n[6:0], sh_n[0]};
          end
        end else begin
          if (sh_n == 8'h00) begin
            sh_m = 8'h80;
          end else if (sh_n == 8'hFF) begin
            sh_m = 8'h7F;
          end else begin
            sh_m = {sh_n[7], sh_n[7:1]};
          end
        end
        mem_req_o.we    = shin_q;
        mem_req_o.wcol  = col_q;
        mem_req_o.wdata = sh_m;
        col_d   = c1;
        ovf_d   = ovf_q | (c1 > {1'b0, w_q});
        chunk_d = 2'd0;
        state_d = (pend_end_q || pend_last_q) ? S_EMIT_RD : S_IDLE;
      end

      S_EMIT_RD: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.rcol = {2'b00, chunk_q, 3'b000};
        state_d        = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          if (last_chunk) begin
            col_d = 7'd0;
            rc_d  = 5'd0;
            ovf_d = 1'b0;
            if (!pend_end_q) begin
              lit_d  = 5'd0;
              endl_d = 1'b0;
            end
            state_d = S_IDLE;
          end else begin
            chunk_d = chunk_q + 2'd1;
            state_d = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      lit_q       <= '0;
      endl_q      <= 1'b0;
      rc_q        <= '0;
      w_q         <= 6'd1;
      ovf_q       <= 1'b0;
      fill_left_q <= '0;
      fill_ones_q <= 1'b0;
      shl_q       <= 1'b0;
      shin_q      <= 1'b0;
      pend_end_q  <= 1'b0;
      pend_last_q <= 1'b0;
      chunk_q     <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      lit_q       <= lit_d;
      endl_q      <= endl_d;
      rc_q        <= rc_d;
      w_q         <= w_d;
      ovf_q       <= ovf_d;
      fill_left_q <= fill_left_d;
      fill_ones_q <= fill_ones_d;
      shl_q       <= shl_d;
      shin_q      <= shin_d;
      pend_end_q  <= pend_end_d;
      pend_last_q <= pend_last_d;
      chunk_q     <= chunk_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_load_o |-> out_free_i)
    else $error("chunk loaded into a full output register");

  a_write_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
      mem_req_o.we |-> (mem_req_o.wcol < {1'b0, w_q}))
    else $error("row store write past the row width");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(mem_req_o.we && mem_req_o.re))
    else $error("row store read and write in the same cycle");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (w_q != 6'd0) && (w_q <= 6'(MAXW)))
    else $error("row width out of range");

  a_row_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_load_o && out_item_o.row_done) |=> in_ready_o)
    else $error("not ready for items after the last chunk of a row");

endmodule

// ===== rtl/glyph_row_delta_decompressor.sv =====
// glyph_row_delta_decompressor: top level, row store, sequencer and output register
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_ready_o   in_data_i   (grd_in_t)
//   out      out  out_valid_o/out_ready_i out_data_o  (grd_out_t)
//
// literal, skip, repeat and end-row bytes are taken in S_IDLE; a shift reads the row store
// there and writes the byte back in S_SHIFT; a fill takes its command, then one byte a cycle
// a row end emits each 64-bit chunk (one to four) by a memory read, then an output load
// no clearing pass: per-byte valid bits are cleared at reset and at glyph start
// the output register holds one chunk; a stall on out_ready_i holds the emission
// depends on grd_pkg, grd_row_mem and grd_ctrl
`timescale 1ns / 1ps

module glyph_row_delta_decompressor #(
  parameter int unsigned ROW_BYTES = grd_pkg::ROW_BYTES_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  grd_pkg::grd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output grd_pkg::grd_out_t out_data_o
);
  import grd_pkg::*;

  grd_mem_req_t    mem_req;
  logic [7:0][7:0] mem_rbytes;
  logic            out_free;
  logic            out_load;
  grd_out_t        out_item;
  logic            out_valid_q;
  grd_out_t        out_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  grd_row_mem #(
    .ROW_BYTES(ROW_BYTES)
  ) u_row_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rbytes_o(mem_rbytes)
  );

  grd_ctrl #(
    .ROW_BYTES(ROW_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .mem_req_o   (mem_req),
    .mem_rbytes_i(mem_rbytes),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_item_o  (out_item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_item;
    end
  end

endmodule

// ===== tb/grd_row_checker.sv =====
// grd_row_checker: op codes for building byte streams, and a checker that follows both
// channels of the decompressor, predicts every row chunk and compares it with what came
// depends on grd_pkg
`timescale 1ns / 1ps

package grd_test_pkg;

  localparam int unsigned OP_DIV = 18;

  typedef enum logic [3:0] {
    OP_LIT1, OP_LIT1_END, OP_LITN, OP_LITN_END, OP_SHL, OP_SHL_END, OP_SHR, OP_SHR_END,
    OP_SKIP, OP_REPEAT, OP_ONES, OP_ZEROS, OP_LIT2, OP_LIT2_END, OP_END
  } op_e;

  function automatic logic [7:0] cmd_byte(op_e op, int unsigned cnt);
    int unsigned n;
    n = (op == OP_END) ? cnt % 4 : cnt % OP_DIV;
    return 8'(int'(op) * OP_DIV + n);
  endfunction

endpackage

module grd_row_checker #(
  parameter int unsigned ROW_BYTES = grd_pkg::ROW_BYTES_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  grd_pkg::grd_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  grd_pkg::grd_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                chunk_count_o,
  output int                row_count_o
);
  import grd_pkg::*;
  import grd_test_pkg::*;

  logic [7:0]  row_img [ROW_BYTES];
  int unsigned col;
  int unsigned lits_left;
  int unsigned rep;
  int unsigned glyph_width;
  bit          end_on_lits;
  bit          ovf;
  grd_out_t    expected_chunks [$];

  int n_fail = 0;
  int n_pending = 0;
  int chunks_seen = 0;
  int rows_seen = 0;

  assign fail_count_o  = n_fail;
  assign pending_o     = n_pending;
  assign chunk_count_o = chunks_seen;
  assign row_count_o   = rows_seen;

  function automatic void clear_state();
    foreach (row_img[i]) row_img[i] = '0;
    col = 0;
    lits_left = 0;
    end_on_lits = 1'b0;
    rep = 0;
    glyph_width = 1;
    ovf = 1'b0;
  endfunction

  function automatic void advance(int unsigned n);
    int unsigned c;
    c = col + n;
    col = (c > 32'(COL_MAX)) ? 32'(COL_MAX) : c;
    if (col > glyph_width) ovf = 1'b1;
  endfunction

  function automatic logic [7:0] col_byte();
    return (col < glyph_width && col < ROW_BYTES) ? row_img[col] : 8'h00;
  endfunction

  function automatic void put_col(logic [7:0] v);
    if (col < glyph_width && col < ROW_BYTES) row_img[col] = v;
    advance(1);
  endfunction

  function automatic logic [7:0] shl(logic [7:0] n);
    if (n == 8'h00) return 8'h01;
    if (n == 8'hFF) return 8'hFE;
    return {n[6:0], n[0]};
  endfunction

  function automatic logic [7:0] shr(logic [7:0] n);
    if (n == 8'h00) return 8'h80;
    if (n == 8'hFF) return 8'h7F;
    return {n[7], n[7:1]};
  endfunction

  function automatic void emit_row(logic [1:0] st, bit last);
    int unsigned chunks;
    int unsigned c_col;
    grd_out_t    c;
    chunks = (glyph_width + 7) / 8;
    for (int unsigned k = 0; k < chunks; k++) begin
      c.row_chunk = '0;
      for (int unsigned b = 0; b < 8; b++) begin
        c_col = k * 8 + b;
        c.row_chunk = {c.row_chunk[55:0],
                       (c_col < glyph_width && c_col < ROW_BYTES) ? row_img[c_col] : 8'h00};
      end
      c.chunk_index  = 2'(k);
      c.repeat_times = 5'(rep + 1);
      c.row_done     = (k == chunks - 1);
      c.glyph_done   = last;
      c.status       = st;
      expected_chunks.push_back(c);
    end
    col = 0;
    rep = 0;
    ovf = 1'b0;
  endfunction

  function automatic void decode_byte(grd_in_t it);
    int unsigned w;
    int unsigned cnt;
    op_e         op;
    bit          ended;
    ended = 1'b0;
    if (it.glyph_start) begin
      clear_state();
      w = it.row_bytes;
      if (w == 0) w = 1;
      if (w > 32) w = 32;
      if (w > ROW_BYTES) w = ROW_BYTES;
      glyph_width = w;
    end
    if (lits_left != 0) begin
      put_col(it.code_byte);
      lits_left--;
      if (lits_left == 0 && end_on_lits) begin
        end_on_lits = 1'b0;
        ended = 1'b1;
      end
    end else begin
      op  = op_e'(it.code_byte / OP_DIV);
      cnt = it.code_byte % OP_DIV;
      case (op)
        OP_LIT1: begin
          advance(cnt);
          lits_left = 1;
        end
        OP_LIT1_END: begin
          advance(cnt);
          lits_left = 1;
          end_on_lits = 1'b1;
        end
        OP_LITN: lits_left = cnt + 1;
        OP_LITN_END: begin
          lits_left = cnt + 1;
          end_on_lits = 1'b1;
        end
        OP_SHL: begin
          advance(cnt);
          put_col(shl(col_byte()));
        end
        OP_SHL_END: begin
          advance(cnt);
          put_col(shl(col_byte()));
          ended = 1'b1;
        end
        OP_SHR: begin
          advance(cnt);
          put_col(shr(col_byte()));
        end
        OP_SHR_END: begin
          advance(cnt);
          put_col(shr(col_byte()));
          ended = 1'b1;
        end
        OP_SKIP: advance(cnt + 1);
        OP_REPEAT: begin
          rep = cnt;
          ended = 1'b1;
        end
        OP_ONES: repeat (cnt + 1) put_col(8'hFF);
        OP_ZEROS: repeat (cnt + 1) put_col(8'h00);
        OP_LIT2: begin
          advance(cnt);
          lits_left = 2;
        end
        OP_LIT2_END: begin
          advance(cnt);
          lits_left = 2;
          end_on_lits = 1'b1;
        end
        OP_END: ended = 1'b1;
        default: ;
      endcase
    end
    if (ended) begin
      emit_row(ovf ? ST_OVF : ST_OK, it.glyph_last);
    end else if (it.glyph_last) begin
      emit_row(ST_UNTERM, 1'b1);
      lits_left = 0;
      end_on_lits = 1'b0;
    end
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (n_fail < 40) $display("t=%0t mismatch %s: got %h expected %h", $time, what, got, want);
    n_fail++;
  endtask

  task automatic check_chunk(grd_out_t got);
    grd_out_t want;
    chunks_seen++;
    if (got.row_done) rows_seen++;
    if (expected_chunks.size() == 0) begin
      report("chunk with none expected", got.row_chunk, '0);
      return;
    end
    want = expected_chunks.pop_front();
    if (got.row_chunk != want.row_chunk) report("row_chunk", got.row_chunk, want.row_chunk);
    if (got.chunk_index != want.chunk_index)
      report("chunk_index", 64'(got.chunk_index), 64'(want.chunk_index));
    if (got.repeat_times != want.repeat_times)
      report("repeat_times", 64'(got.repeat_times), 64'(want.repeat_times));
    if (got.row_done != want.row_done)
      report("row_done", 64'(got.row_done), 64'(want.row_done));
    if (got.glyph_done != want.glyph_done)
      report("glyph_done", 64'(got.glyph_done), 64'(want.glyph_done));
    if (got.status != want.status) report("status", 64'(got.status), 64'(want.status));
  endtask

  // results leave strictly after their byte, so compare before predicting
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_chunks.delete();
      n_pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_chunk(out_data_i);
      if (in_valid_i && in_ready_i) decode_byte(in_data_i);
      n_pending = expected_chunks.size();
    end
  end

endmodule

// ===== tb/glyph_row_delta_decompressor_test.sv =====
// glyph_row_delta_decompressor_test: drives glyph byte streams into the decompressor,
// directed first and then random, with random stalls on both sides, and gives the verdict
// depends on grd_pkg, grd_test_pkg, grd_row_checker and the block itself
`timescale 1ns / 1ps

module glyph_row_delta_decompressor_test;
  import grd_pkg::*;
  import grd_test_pkg::*;

  localparam int LIMIT = 200000;
  localparam int N_ITEMS = 110;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  grd_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  grd_out_t out_data_o;

  grd_in_t stream_q [$];
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int cycles = 0;
  int items_sent = 0;
  int n_streams = 0;
  int fail_count;
  int pending;
  int chunk_count;
  int row_count;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  glyph_row_delta_decompressor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  grd_row_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .chunk_count_o (chunk_count),
    .row_count_o   (row_count)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d chunks still expected", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left != 0) stall_left--;
      else if ($urandom_range(99) < stall_pct) stall_left = $urandom_range(1, 10);
      out_ready_i <= (stall_left == 0);
    end
  end

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_count();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 3);
  endfunction

  function automatic op_e pick_op(bit ending);
    if (ending) begin
      case ($urandom_range(0, 6))
        0: return OP_LIT1_END;
        1: return OP_LITN_END;
        2: return OP_SHL_END;
        3: return OP_SHR_END;
        4: return OP_REPEAT;
        5: return OP_LIT2_END;
        default: return OP_END;
      endcase
    end
    case ($urandom_range(0, 7))
      0: return OP_LIT1;
      1: return OP_LITN;
      2: return OP_SHL;
      3: return OP_SHR;
      4: return OP_SKIP;
      5: return OP_ONES;
      6: return OP_ZEROS;
      default: return OP_LIT2;
    endcase
  endfunction

  function automatic void push_code(logic [7:0] b);
    grd_in_t it;
    it.code_byte   = b;
    it.glyph_start = 1'b0;
    it.row_bytes   = 6'($urandom_range(0, 63));
    it.glyph_last  = 1'b0;
    stream_q.push_back(it);
  endfunction

  function automatic void push_op(op_e op, int unsigned cnt);
    int unsigned n_lits;
    push_code(cmd_byte(op, cnt));
    case (op)
      OP_LIT1, OP_LIT1_END: n_lits = 1;
      OP_LITN, OP_LITN_END: n_lits = cnt + 1;
      OP_LIT2, OP_LIT2_END: n_lits = 2;
      default: n_lits = 0;
    endcase
    repeat (n_lits) push_code(rand_data());
  endfunction

  function automatic void build_row();
    // runaway row: column runs into saturation
    if ($urandom_range(0, 11) == 0) begin
      repeat (8) push_op(($urandom_range(0, 1) != 0) ? OP_SKIP : OP_ONES, 17);
      push_op(OP_END, $urandom_range(0, 3));
      return;
    end
    repeat ($urandom_range(0, 4)) push_op(pick_op(1'b0), pick_count());
    push_op(pick_op(1'b1), pick_count());
  endfunction

  function automatic void build_glyph();
    logic [5:0]  w;
    int unsigned cut;
    stream_q.delete();
    case ($urandom_range(0, 9))
      0: w = 6'($urandom_range(0, 63));
      1, 2: w = 6'($urandom_range(9, 32));
      default: w = 6'($urandom_range(1, 8));
    endcase
    repeat ($urandom_range(1, 4)) build_row();
    stream_q[0].glyph_start = 1'b1;
    stream_q[0].row_bytes = w;
    case ($urandom_range(0, 9))
      0, 1: begin
        cut = $urandom_range(0, stream_q.size() - 1);
        while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
        stream_q[cut].glyph_last = 1'b1;
      end
      2: ;
      default: stream_q[stream_q.size() - 1].glyph_last = 1'b1;
    endcase
    // stray bytes after the glyph, decoded against the kept row
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) push_code(rand_data());
      stream_q[stream_q.size() - 1].glyph_last = 1'($urandom_range(0, 1));
    end
  endfunction

  task automatic send_byte(grd_in_t it);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_stream();
    n_streams++;
    foreach (stream_q[i]) send_byte(stream_q[i]);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_pct = 20;
    stall_pct = 20;

    // width zero, fill past the row, end-of-row on the top byte value
    stream_q.delete();
    push_code(cmd_byte(OP_ONES, 17));
    push_code(cmd_byte(OP_END, 3));
    stream_q[0].glyph_start = 1'b1;
    stream_q[0].row_bytes = 6'd0;
    // oversized width, every op but the plain end-row, shifts of the edge values, unterminated end
    push_code(cmd_byte(OP_LITN_END, 1));
    push_code(8'hFF);
    push_code(8'h00);
    push_code(cmd_byte(OP_SHL, 0));
    push_code(cmd_byte(OP_SHR, 0));
    push_code(cmd_byte(OP_SHL_END, 1));
    push_code(cmd_byte(OP_LIT1, 0));
    push_code(8'h5A);
    push_code(cmd_byte(OP_LITN, 1));
    push_code(8'h96);
    push_code(8'hC3);
    push_code(cmd_byte(OP_ONES, 0));
    push_code(cmd_byte(OP_ZEROS, 0));
    push_code(cmd_byte(OP_SKIP, 1));
    push_code(cmd_byte(OP_REPEAT, 17));
    push_code(cmd_byte(OP_LIT1_END, 0));
    push_code(8'h3C);
    push_code(cmd_byte(OP_LIT2_END, 0));
    push_code(8'h81);
    push_code(8'h7E);
    push_code(cmd_byte(OP_SHR_END, 0));
    push_code(cmd_byte(OP_LIT2, 0));
    push_code(8'hA5);
    stream_q[2].glyph_start = 1'b1;
    stream_q[2].row_bytes = 6'd63;
    stream_q[stream_q.size() - 1].glyph_last = 1'b1;
    send_stream();

    while (items_sent < N_ITEMS - 40) begin
      case ($urandom_range(0, 2))
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 15;
          stall_pct = 15;
        end
        default: begin
          gap_pct = 50;
          stall_pct = 50;
        end
      endcase
      build_glyph();
      send_stream();
    end

    // closing stretch at full rate
    gap_pct = 0;
    stall_pct = 0;
    do begin
      build_glyph();
      send_stream();
    end while (items_sent < N_ITEMS);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("sent %0d bytes in %0d glyph streams with random gaps and stalls",
             items_sent, n_streams);
    $display("checked %0d row chunks making up %0d rows", chunk_count, row_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
